>>> rtl/rtdwc_pkg.sv
// Package for the rotate-then-drive waypoint controller core.
// Holds the shared widths, codes, control and status structs and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package rtdwc_pkg;

    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int ARRIVE_W   = 21;
    localparam int YTH_W      = 16;
    localparam int LIN_W      = 15;
    localparam int ANG_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int YAW_W      = 17;
    localparam int ERR_W      = 18;
    localparam int Z_W        = 28;
    localparam int ACC_W      = 36;
    localparam int CX_W       = 40;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 48;
    localparam int DIST_W     = 32;
    localparam int RAD_W      = 64;
    localparam int CNT_W      = 5;

    localparam int ATAN_ENTRIES = 24;
    localparam int SQRT_STEPS   = 32;
    localparam int QMAC_STEPS   = 6;

    localparam int DEF_POSITION_WIDTH    = 32;
    localparam int DEF_CORDIC_ITERATIONS = 16;

    localparam logic signed [ERR_W-1:0] YAW_PI     = 18'sd51472;
    localparam logic signed [ERR_W-1:0] YAW_TWO_PI = 18'sd102944;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q24 = 28'sd26353589;

    localparam logic CMD_ODOM = 1'b0;
    localparam logic CMD_GOAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR     = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP   = 2'd0,
        MODE_ROTATE = 2'd1,
        MODE_DRIVE  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_QMAC   = 4'd2,
        OP_CINIT  = 4'd3,
        OP_CSTEP  = 4'd4,
        OP_YAW    = 4'd5,
        OP_DINIT  = 4'd6,
        OP_SQ     = 4'd7,
        OP_SQRT   = 4'd8,
        OP_DECIDE = 4'd9,
        OP_MULT   = 4'd10,
        OP_OUT    = 4'd11
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic compute;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic                     command;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } pose_t;

    typedef struct packed {
        logic [LIN_W-1:0]        linear_velocity;
        logic signed [ANG_W-1:0] angular_velocity;
        logic                    goal_reached;
        logic [MODE_W-1:0]       motion_mode;
    } result_t;

    // atan(2^-i) in Q.24
    function automatic logic [23:0] atan_q24(input logic [CNT_W-1:0] i);
        logic [23:0] v;
        case (i)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/rtdwc_pose_if.sv
// Valid/ready channel carrying one pose word (odometry or goal).
// Depends on rtdwc_pkg for field widths.
`timescale 1ns / 1ps

interface rtdwc_pose_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       command;
    logic signed [rtdwc_pkg::POS_W-1:0]         pos_x;
    logic signed [rtdwc_pkg::POS_W-1:0]         pos_y;
    logic signed [rtdwc_pkg::QUAT_W-1:0]        quat_x;
    logic signed [rtdwc_pkg::QUAT_W-1:0]        quat_y;
    logic signed [rtdwc_pkg::QUAT_W-1:0]        quat_z;
    logic signed [rtdwc_pkg::QUAT_W-1:0]        quat_w;

    modport source (output valid, command, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink (input valid, command, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  output ready);
endinterface

>>> rtl/rtdwc_cmd_if.sv
// Valid/ready channel carrying one velocity command word.
// Depends on rtdwc_pkg for field widths.
`timescale 1ns / 1ps

interface rtdwc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [rtdwc_pkg::LIN_W-1:0]         linear_velocity;
    logic signed [rtdwc_pkg::ANG_W-1:0]  angular_velocity;
    logic                                goal_reached;
    logic [rtdwc_pkg::MODE_W-1:0]        motion_mode;

    modport source (output valid, linear_velocity, angular_velocity, goal_reached, motion_mode,
                    input ready);
    modport sink (input valid, linear_velocity, angular_velocity, goal_reached, motion_mode,
                  output ready);
endinterface

>>> rtl/rtdwc_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on rtdwc_pkg for field widths.
`timescale 1ns / 1ps

interface rtdwc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rtdwc_pkg::CFG_IDX_W-1:0]     index;
    logic [rtdwc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rtdwc_datapath.sv
// Datapath: pose and goal registers, shared multiplier, CORDIC yaw, bitwise square root,
// control law and output register. Sequenced by rtdwc_ctrl. Depends on rtdwc_pkg.
`timescale 1ns / 1ps

module rtdwc_datapath #(
    parameter int POSITION_WIDTH = rtdwc_pkg::DEF_POSITION_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rtdwc_pkg::ctrl_cmd_t                  cmd,
    output rtdwc_pkg::dp_status_t                 status,
    input  rtdwc_pkg::pose_t                      pose,
    input  logic                                  cfg_valid,
    input  logic [rtdwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtdwc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rtdwc_pkg::result_t                    result,
    output logic                                  out_valid,
    input  logic                                  out_ready
);
    import rtdwc_pkg::*;

    localparam int PW = (POSITION_WIDTH < POS_W) ? POSITION_WIDTH : POS_W;

    // configuration
    logic [GAIN_W-1:0]   lin_gain_reg, ang_gain_reg, max_lin_reg, max_ang_reg;
    logic [ARRIVE_W-1:0] arrive_reg;
    logic [YTH_W-1:0]    yaw_thr_reg;

    // current word
    logic                     cmd_bit_reg;
    logic signed [PW-1:0]     px_reg, py_reg;
    logic signed [QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;

    // yaw
    logic signed [ACC_W-1:0] acc_a_reg, acc_b_reg;
    logic signed [CX_W-1:0]  cx_reg, cy_reg;
    logic signed [Z_W-1:0]   cz_reg;
    logic                    zero_reg;

    // block state
    logic signed [PW-1:0]    robot_x_reg, robot_y_reg, target_x_reg, target_y_reg;
    logic signed [YAW_W-1:0] robot_yaw_reg, target_yaw_reg;
    logic                    have_odo_reg, have_tgt_reg, reached_reg;

    // distance and control law
    logic [30:0]              ax_reg, ay_reg;
    logic                     sat_reg;
    logic [RAD_W-1:0]         sum_reg, root_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic signed [ERR_W-1:0]  err_reg;
    mode_t                    mode_reg;
    logic signed [PROD_W-1:0] prod_reg;

    result_t result_reg;
    logic    out_valid_reg;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_QMAC:
            begin
                case (cmd.idx)
                    5'd0:    begin mul_a = MUL_W'(qw_reg); mul_b = MUL_W'(qw_reg); end
                    5'd1:    begin mul_a = MUL_W'(qx_reg); mul_b = MUL_W'(qx_reg); end
                    5'd2:    begin mul_a = MUL_W'(qy_reg); mul_b = MUL_W'(qy_reg); end
                    5'd3:    begin mul_a = MUL_W'(qz_reg); mul_b = MUL_W'(qz_reg); end
                    5'd4:    begin mul_a = MUL_W'(qx_reg); mul_b = MUL_W'(qy_reg); end
                    default: begin mul_a = MUL_W'(qw_reg); mul_b = MUL_W'(qz_reg); end
                endcase
            end
            OP_SQ:
            begin
                if (cmd.idx[0])
                begin
                    mul_a = MUL_W'(ay_reg);
                    mul_b = MUL_W'(ay_reg);
                end
                else
                begin
                    mul_a = MUL_W'(ax_reg);
                    mul_b = MUL_W'(ax_reg);
                end
            end
            OP_MULT:
            begin
                if (mode_reg == MODE_ROTATE)
                begin
                    mul_a = MUL_W'(ang_gain_reg);
                    mul_b = MUL_W'(err_reg);
                end
                else
                begin
                    mul_a = MUL_W'(lin_gain_reg);
                    mul_b = MUL_W'(dist_reg);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // CORDIC start vector, moved into the right half plane
    logic signed [ACC_W-1:0] vec_a, vec_b;
    logic signed [CX_W-1:0]  init_x, init_y;
    logic signed [Z_W-1:0]   init_z;

    always_comb
    begin
        vec_a = acc_a_reg;
        vec_b = acc_b_reg <<< 1;
        init_x = CX_W'(vec_a);
        init_y = CX_W'(vec_b);
        init_z = '0;
        if (vec_a < 0)
        begin
            if (vec_b >= 0)
            begin
                init_x = CX_W'(vec_b);
                init_y = -CX_W'(vec_a);
                init_z = HALF_PI_Q24;
            end
            else
            begin
                init_x = -CX_W'(vec_b);
                init_y = CX_W'(vec_a);
                init_z = -HALF_PI_Q24;
            end
        end
    end

    // CORDIC micro-rotation
    logic signed [CX_W-1:0] shx, shy;
    logic signed [Z_W-1:0]  atan_v;

    assign shx    = cx_reg >>> cmd.idx;
    assign shy    = cy_reg >>> cmd.idx;
    assign atan_v = Z_W'(atan_q24(cmd.idx));

    // Q.24 angle rounded half away from zero to Q.14, clamped to +-pi
    logic [Z_W-1:0]          z_abs;
    logic [17:0]             z_mag;
    logic [YAW_W-1:0]        z_clamp;
    logic signed [YAW_W-1:0] yaw_val;

    always_comb
    begin
        z_abs   = (cz_reg < 0) ? Z_W'(-cz_reg) : Z_W'(cz_reg);
        z_mag   = 18'((z_abs + Z_W'(512)) >> 10);
        z_clamp = (z_mag > 18'(YAW_PI)) ? YAW_W'(YAW_PI) : z_mag[YAW_W-1:0];
        if (zero_reg)
            yaw_val = '0;
        else if (cz_reg < 0)
            yaw_val = -signed'(z_clamp);
        else
            yaw_val = signed'(z_clamp);
    end

    // position deltas
    logic signed [32:0] dx, dy;
    logic [32:0]        abs_x, abs_y;

    always_comb
    begin
        dx    = 33'(target_x_reg) - 33'(robot_x_reg);
        dy    = 33'(target_y_reg) - 33'(robot_y_reg);
        abs_x = (dx < 0) ? 33'(-dx) : 33'(dx);
        abs_y = (dy < 0) ? 33'(-dy) : 33'(dy);
    end

    // one root bit per step
    logic [RAD_W-1:0] sq_bit, sq_trial;

    assign sq_bit   = RAD_W'(1) << (7'd62 - 7'({cmd.idx, 1'b0}));
    assign sq_trial = root_reg + sq_bit;

    // distance and wrapped yaw error
    logic [DIST_W-1:0]       dist_val;
    logic signed [ERR_W-1:0] err_raw, err_wrap;
    logic [ERR_W-1:0]        err_abs;

    always_comb
    begin
        if (sat_reg || root_reg > RAD_W'(64'h8000_0000))
            dist_val = 32'h8000_0000;
        else
            dist_val = root_reg[DIST_W-1:0];
        err_raw = ERR_W'(target_yaw_reg) - ERR_W'(robot_yaw_reg);
        if (err_raw > YAW_PI)
            err_wrap = err_raw - YAW_TWO_PI;
        else if (err_raw < -YAW_PI)
            err_wrap = err_raw + YAW_TWO_PI;
        else
            err_wrap = err_raw;
        err_abs = (err_wrap < 0) ? ERR_W'(-err_wrap) : ERR_W'(err_wrap);
    end

    // final scaling and clamps
    logic [PROD_W-1:0] p_abs;
    logic [33:0]       ang_mag;
    logic [ANG_W-1:0]  ang_clamp;
    logic [30:0]       lin_raw;
    logic [LIN_W-1:0]  lin_clamp;
    result_t           res_val;

    always_comb
    begin
        p_abs     = (prod_reg < 0) ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        ang_mag   = 34'((p_abs + PROD_W'(8192)) >> 14);
        ang_clamp = (ang_mag > 34'(max_ang_reg)) ? ANG_W'(max_ang_reg) : ang_mag[ANG_W-1:0];
        lin_raw   = prod_reg[46:16];
        lin_clamp = (lin_raw > 31'(max_lin_reg)) ? max_lin_reg : lin_raw[LIN_W-1:0];

        res_val.linear_velocity  = '0;
        res_val.angular_velocity = '0;
        res_val.goal_reached     = 1'b0;
        res_val.motion_mode      = mode_reg;
        case (mode_reg)
            MODE_ROTATE:
                res_val.angular_velocity = (prod_reg < 0) ? -signed'(ang_clamp)
                                                          : signed'(ang_clamp);
            MODE_DRIVE:
                res_val.linear_velocity = lin_clamp;
            default:
                res_val.goal_reached = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg   <= 15'd8192;
            ang_gain_reg   <= 15'd8192;
            arrive_reg     <= 21'd13107;
            yaw_thr_reg    <= 16'd16384;
            max_lin_reg    <= 15'd8192;
            max_ang_reg    <= 15'd16384;
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            robot_yaw_reg  <= '0;
            target_yaw_reg <= '0;
            have_odo_reg   <= 1'b0;
            have_tgt_reg   <= 1'b0;
            reached_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LINEAR_GAIN:     lin_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_ANGULAR_GAIN:    ang_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_ARRIVE_DISTANCE: arrive_reg   <= cfg_data[ARRIVE_W-1:0];
                    REG_YAW_THRESHOLD:   yaw_thr_reg  <= cfg_data[YTH_W-1:0];
                    REG_MAX_LINEAR:      max_lin_reg  <= cfg_data[GAIN_W-1:0];
                    REG_MAX_ANGULAR:     max_ang_reg  <= cfg_data[GAIN_W-1:0];
                    default:             ;
                endcase
            end

            if (cmd.op == OP_YAW)
            begin
                if (cmd_bit_reg == CMD_GOAL)
                begin
                    target_x_reg   <= px_reg;
                    target_y_reg   <= py_reg;
                    target_yaw_reg <= yaw_val;
                    have_tgt_reg   <= 1'b1;
                    reached_reg    <= 1'b0;
                end
                else
                begin
                    robot_x_reg   <= px_reg;
                    robot_y_reg   <= py_reg;
                    robot_yaw_reg <= yaw_val;
                    have_odo_reg  <= 1'b1;
                end
            end

            if (cmd.op == OP_DECIDE)
                reached_reg <= (dist_val < DIST_W'(arrive_reg));

            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_bit_reg <= pose.command;
                px_reg      <= PW'(pose.pos_x);
                py_reg      <= PW'(pose.pos_y);
                qx_reg      <= pose.quat_x;
                qy_reg      <= pose.quat_y;
                qz_reg      <= pose.quat_z;
                qw_reg      <= pose.quat_w;
                acc_a_reg   <= '0;
                acc_b_reg   <= '0;
            end
            OP_QMAC:
            begin
                if (cmd.idx == 5'd2 || cmd.idx == 5'd3)
                    acc_a_reg <= acc_a_reg - ACC_W'(mul_p);
                else if (cmd.idx == 5'd0 || cmd.idx == 5'd1)
                    acc_a_reg <= acc_a_reg + ACC_W'(mul_p);
                else
                    acc_b_reg <= acc_b_reg + ACC_W'(mul_p);
            end
            OP_CINIT:
            begin
                cx_reg   <= init_x;
                cy_reg   <= init_y;
                cz_reg   <= init_z;
                zero_reg <= (vec_a == 0) && (vec_b == 0);
            end
            OP_CSTEP:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + shy;
                    cy_reg <= cy_reg - shx;
                    cz_reg <= cz_reg + atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg - shy;
                    cy_reg <= cy_reg + shx;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            OP_DINIT:
            begin
                ax_reg   <= abs_x[30:0];
                ay_reg   <= abs_y[30:0];
                sat_reg  <= (|abs_x[32:31]) || (|abs_y[32:31]);
                root_reg <= '0;
            end
            OP_SQ:
            begin
                if (cmd.idx[0])
                    sum_reg <= sum_reg + RAD_W'(mul_p);
                else
                    sum_reg <= RAD_W'(mul_p);
            end
            OP_SQRT:
            begin
                if (sum_reg >= sq_trial)
                begin
                    sum_reg  <= sum_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_DECIDE:
            begin
                dist_reg <= dist_val;
                err_reg  <= err_wrap;
                if (dist_val < DIST_W'(arrive_reg))
                    mode_reg <= MODE_STOP;
                else if (err_abs >= ERR_W'(yaw_thr_reg))
                    mode_reg <= MODE_ROTATE;
                else
                    mode_reg <= MODE_DRIVE;
            end
            OP_MULT:
                prod_reg <= mul_p[PROD_W-1:0];
            OP_OUT:
                result_reg <= res_val;
            default:
                ;
        endcase
    end

    assign status.compute  = (cmd_bit_reg == CMD_GOAL) ? have_odo_reg
                                                       : (have_tgt_reg && !reached_reg);
    assign status.out_busy = out_valid_reg && !out_ready;
    assign result          = result_reg;
    assign out_valid       = out_valid_reg;

endmodule

>>> rtl/rtdwc_ctrl.sv
// Controller: one-hot sequencer that walks the datapath through yaw, distance and control law.
// Depends on rtdwc_pkg.
`timescale 1ns / 1ps

module rtdwc_ctrl #(
    parameter int CORDIC_ITERATIONS = rtdwc_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtdwc_pkg::dp_status_t status,
    output rtdwc_pkg::ctrl_cmd_t  cmd
);
    import rtdwc_pkg::*;

    localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                                      : ATAN_ENTRIES;
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] QMAC_LAST   = CNT_W'(QMAC_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_QMAC   = 11'b000_0000_0010,
        ST_CINIT  = 11'b000_0000_0100,
        ST_CSTEP  = 11'b000_0000_1000,
        ST_YAW    = 11'b000_0001_0000,
        ST_DINIT  = 11'b000_0010_0000,
        ST_SQ     = 11'b000_0100_0000,
        ST_SQRT   = 11'b000_1000_0000,
        ST_DECIDE = 11'b001_0000_0000,
        ST_MULT   = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_QMAC;
                    cnt_next   = '0;
                end
            end
            ST_QMAC:
            begin
                cmd.op = OP_QMAC;
                if (cnt_reg == QMAC_LAST)
                    state_next = ST_CINIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_CINIT:
            begin
                cmd.op     = OP_CINIT;
                cnt_next   = '0;
                state_next = ST_CSTEP;
            end
            ST_CSTEP:
            begin
                cmd.op = OP_CSTEP;
                if (cnt_reg == CORDIC_LAST)
                    state_next = ST_YAW;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_YAW:
            begin
                // flags still hold their values from before this word here
                cmd.op     = OP_YAW;
                state_next = status.compute ? ST_DINIT : ST_IDLE;
            end
            ST_DINIT:
            begin
                cmd.op     = OP_DINIT;
                cnt_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg[0])
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                    state_next = ST_DECIDE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.op     = OP_MULT;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> rtl/rotate_then_drive_waypoint_controller_core.sv
// Top level of the rotate-then-drive waypoint controller: controller plus datapath.
// Depends on rtdwc_pkg, the three channel interfaces, rtdwc_ctrl and rtdwc_datapath.
//
// Usage:
//   pose_in  - valid/ready; each word is an odometry pose (command 0) or a goal (command 1).
//   cmd_out  - valid/ready; one velocity word per pose word that triggers a computation
//              (goal with odometry present, or odometry while a goal is active and unreached).
//   cfg      - register writes; always ready, write only while the block is idle.
// Timing: one word at a time. A word that yields no output runs the quaternion products on the
//   shared multiplier, then one CORDIC step per cycle. A word that yields output adds the
//   distance set-up, the squares, the 32-step bitwise square root, which dominates, the decision,
//   the gain multiply and the output write.
// The result sits in an output register; if cmd_out stalls, the next word is still taken and
//   processed, and the block waits only when it must write a second result.
// Reset: gains and limits return to their defaults, poses clear, no goal is active
//   and the reached flag is set.
`timescale 1ns / 1ps

module rotate_then_drive_waypoint_controller_core #(
    parameter int POSITION_WIDTH    = rtdwc_pkg::DEF_POSITION_WIDTH,
    parameter int CORDIC_ITERATIONS = rtdwc_pkg::DEF_CORDIC_ITERATIONS
) (
    input logic         clk,
    input logic         rst_n,
    rtdwc_pose_if.sink  pose_in,
    rtdwc_cmd_if.source cmd_out,
    rtdwc_cfg_if.sink   cfg
);
    import rtdwc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    pose_t      pose;
    result_t    result;
    logic       out_valid;

    assign pose.command = pose_in.command;
    assign pose.pos_x   = pose_in.pos_x;
    assign pose.pos_y   = pose_in.pos_y;
    assign pose.quat_x  = pose_in.quat_x;
    assign pose.quat_y  = pose_in.quat_y;
    assign pose.quat_z  = pose_in.quat_z;
    assign pose.quat_w  = pose_in.quat_w;

    assign cfg.ready = 1'b1;

    rtdwc_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pose_in.valid),
        .in_ready (pose_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rtdwc_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pose      (pose),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .result    (result),
        .out_valid (out_valid),
        .out_ready (cmd_out.ready)
    );

    assign cmd_out.valid            = out_valid;
    assign cmd_out.linear_velocity  = result.linear_velocity;
    assign cmd_out.angular_velocity = result.angular_velocity;
    assign cmd_out.goal_reached     = result.goal_reached;
    assign cmd_out.motion_mode      = result.motion_mode;

endmodule
